// File: rtl/checkpoint_sequence_supervisor_defines.svh
// Assertion macros for the checkpoint sequence supervisor
`ifndef CHECKPOINT_SEQUENCE_SUPERVISOR_DEFINES_SVH
`define CHECKPOINT_SEQUENCE_SUPERVISOR_DEFINES_SVH

// antecedent in one cycle implies consequent in the next, outside reset
`define CSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// consequent holds in the cycle after reset is applied
`define CSS_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) else $error(msg);

`endif

// File: rtl/css_pkg.sv
// Package: shared types and constants of the checkpoint sequence supervisor
`timescale 1ns / 1ps
package css_pkg;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 4;
    localparam int CPID_W = 16;
    localparam int KEY_W  = 32;
    localparam int LEN_W  = 5;
    localparam int IDX_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECKPOINT = 2'd0,
        CMD_ENTRY      = 2'd1,
        CMD_HEADER     = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              hdr_we;
        logic              ent_we;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
        logic [CPID_W-1:0] cpid;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
    } t_load;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             violation;
    } t_report;

endpackage

// File: rtl/css_in_if.sv
// Interface: checkpoint and load command channel
`timescale 1ns / 1ps
interface css_in_if;
    logic                         valid;
    logic                         ready;
    logic [css_pkg::CMD_W-1:0]    cmd;
    logic [css_pkg::SLOT_W-1:0]   slot;
    logic [css_pkg::POS_W-1:0]    position;
    logic [css_pkg::CPID_W-1:0]   checkpoint_id;
    logic [css_pkg::KEY_W-1:0]    fault_key;
    logic [css_pkg::LEN_W-1:0]    seq_length;

    modport source (
        output valid, cmd, slot, position, checkpoint_id, fault_key, seq_length,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot, position, checkpoint_id, fault_key, seq_length,
        output ready
    );
endinterface

// File: rtl/css_out_if.sv
// Interface: report channel
`timescale 1ns / 1ps
interface css_out_if;
    logic                       valid;
    logic                       ready;
    logic [css_pkg::KEY_W-1:0]  report_key;
    logic                       violation;
    logic                       last;

    modport source (
        output valid, report_key, violation, last,
        input  ready
    );
    modport sink (
        input  valid, report_key, violation, last,
        output ready
    );
endinterface

// File: rtl/checkpoint_sequence_supervisor.sv
// Top level: checkpoint sequence supervisor built from a chain of monitor cells
//
// Input channel i_cp carries commands: checkpoint event, sequence entry write and
// monitor header write. Loads take effect at the transfer and produce no report.
// A checkpoint, when enable is set, launches a token down the chain of MONITORS
// cells, one cell per cycle; each active cell compares the checkpoint against its
// expected entry and may produce one report (key, violation). Reports leave on
// o_rep in slot order, the final one carrying last.
// A checkpoint occupies the block through the transfer, two launch stages, a step
// through each cell and a flush; a load occupies it only for its transfer. The input
// is accepted again while the last report still waits in the output register.
// The final report is placed in the output register by the flush; an earlier report
// is moved to the output register when the next one is produced.
// When o_rep stalls, the token halts at a reporting cell while one report is held
// and another waits in the output register; the chain resumes when it drains.
// Reset (i_rst_n low, synchronous) clears enable, all lengths and cursors, so every
// monitor is inactive; sequence entries and keys hold no value until written.
// Configuration: i_cfg_we writes i_cfg_wdata into enable; the user writes only while the block is idle, unchecked.
`timescale 1ns / 1ps
module checkpoint_sequence_supervisor #(
    parameter int MONITORS  = 16,
    parameter int SEQ_DEPTH = 16,
    parameter int ID_WIDTH  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    css_in_if.sink     i_cp,
    css_out_if.source  o_rep,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata
);

    localparam int EW = (ID_WIDTH < css_pkg::CPID_W) ? ID_WIDTH : css_pkg::CPID_W;

    logic                       r_enable;
    logic                       r_start1;
    logic                       r_start2;
    logic [EW-1:0]              r_id;
    logic                       r_tail;
    logic                       r_hold_v;
    logic [css_pkg::KEY_W-1:0]  r_hold_key;
    logic                       r_hold_viol;
    logic                       r_out_v;
    logic [css_pkg::KEY_W-1:0]  r_out_key;
    logic                       r_out_viol;
    logic                       r_out_last;

    logic                       accept;
    logic                       ckpt_go;
    css_pkg::t_load             load;
    logic                       tok [MONITORS+1];
    logic [EW-1:0]              ids [MONITORS+1];
    css_pkg::t_report           reps [MONITORS];
    css_pkg::t_report           rep;
    logic                       chain_busy;
    logic                       out_free;
    logic                       adv;
    logic                       flush;

    assign accept = i_cp.valid && i_cp.ready;

    always_comb begin
        load.hdr_we   = 1'b0;
        load.ent_we   = 1'b0;
        load.slot     = i_cp.slot;
        load.position = i_cp.position;
        load.cpid     = i_cp.checkpoint_id;
        load.key      = i_cp.fault_key;
        load.len      = i_cp.seq_length;
        ckpt_go       = 1'b0;
        unique case (i_cp.cmd)
            css_pkg::CMD_CHECKPOINT: ckpt_go     = accept && r_enable;
            css_pkg::CMD_ENTRY:      load.ent_we = accept;
            css_pkg::CMD_HEADER:     load.hdr_we = accept;
            default: ;
        endcase
    end

    assign tok[0] = r_start2;
    assign ids[0] = r_id;

    for (genvar k = 0; k < MONITORS; k++) begin : g_cell
        css_cell #(
            .IDX       (k),
            .SEQ_DEPTH (SEQ_DEPTH),
            .EW        (EW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (load),
            .i_adv   (adv),
            .i_tok   (tok[k]),
            .i_id    (ids[k]),
            .o_tok   (tok[k+1]),
            .o_id    (ids[k+1]),
            .o_rep   (reps[k])
        );
    end

    always_comb begin
        rep        = '0;
        chain_busy = 1'b0;
        for (int k = 0; k < MONITORS; k++) begin
            if (reps[k].valid) begin
                rep = reps[k];
            end
            chain_busy = chain_busy | tok[k+1];
        end
    end

    assign out_free = !r_out_v || o_rep.ready;
    assign adv      = !(rep.valid && r_hold_v && !out_free);
    assign flush    = r_tail && (!r_hold_v || out_free);

    assign i_cp.ready = !(r_start1 || r_start2 || chain_busy || r_tail || r_hold_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_start1 <= 1'b0;
            r_start2 <= 1'b0;
            r_tail   <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            r_start1 <= ckpt_go;
            r_start2 <= r_start1;
            if (adv && tok[MONITORS]) begin
                r_tail <= 1'b1;
            end else if (flush) begin
                r_tail <= 1'b0;
            end
            if (rep.valid && adv) begin
                r_hold_v <= 1'b1;
            end else if (flush) begin
                r_hold_v <= 1'b0;
            end
            if ((rep.valid && adv && r_hold_v) || (flush && r_hold_v)) begin
                r_out_v <= 1'b1;
            end else if (o_rep.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ckpt_go) begin
            r_id <= i_cp.checkpoint_id[EW-1:0];
        end
        if (rep.valid && adv) begin
            r_hold_key  <= rep.key;
            r_hold_viol <= rep.violation;
        end
        if (rep.valid && adv && r_hold_v) begin
            r_out_key  <= r_hold_key;
            r_out_viol <= r_hold_viol;
            r_out_last <= 1'b0;
        end else if (flush && r_hold_v) begin
            r_out_key  <= r_hold_key;
            r_out_viol <= r_hold_viol;
            r_out_last <= 1'b1;
        end
    end

    assign o_rep.valid      = r_out_v;
    assign o_rep.report_key = r_out_key;
    assign o_rep.violation  = r_out_viol;
    assign o_rep.last       = r_out_last;

endmodule

// File: rtl/css_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module css_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/css_cell.sv
// Monitor cell: one monitor's key, length, cursor and sequence memory
`timescale 1ns / 1ps
module css_cell #(
    parameter int IDX       = 0,
    parameter int SEQ_DEPTH = 16,
    parameter int EW        = 16,
    localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1,
    localparam int LW = $clog2(SEQ_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  css_pkg::t_load   i_load,
    input  logic             i_adv,
    input  logic             i_tok,
    input  logic [EW-1:0]    i_id,
    output logic             o_tok,
    output logic [EW-1:0]    o_id,
    output css_pkg::t_report o_rep
);

    logic                          r_tok;
    logic [EW-1:0]                 r_id;
    logic [AW-1:0]                 r_cur;
    logic [LW-1:0]                 r_len;
    logic [css_pkg::KEY_W-1:0]     r_key;

    logic                          hit;
    logic [css_pkg::IDX_W-1:0]     pos_x;
    logic [css_pkg::IDX_W-1:0]     len_x;
    logic [LW-1:0]                 len_sat;
    logic                          ent_we;
    logic [EW-1:0]                 rdata;
    logic [LW-1:0]                 nxt;
    logic                          active;
    logic                          match;
    logic                          wrap;

    assign hit     = (css_pkg::IDX_W'(i_load.slot) == css_pkg::IDX_W'(IDX));
    assign pos_x   = css_pkg::IDX_W'(i_load.position);
    assign len_x   = css_pkg::IDX_W'(i_load.len);
    assign len_sat = (len_x > css_pkg::IDX_W'(SEQ_DEPTH)) ? LW'(SEQ_DEPTH) : LW'(len_x);
    assign ent_we  = i_load.ent_we && hit && (pos_x < css_pkg::IDX_W'(SEQ_DEPTH));

    css_ram #(
        .WIDTH (EW),
        .DEPTH (SEQ_DEPTH)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (pos_x[AW-1:0]),
        .i_wdata (i_load.cpid[EW-1:0]),
        .i_raddr (r_cur),
        .o_rdata (rdata)
    );

    assign nxt    = LW'(r_cur) + LW'(1);
    assign active = r_tok && (r_len != '0);
    assign match  = (rdata == r_id);
    assign wrap   = (nxt >= r_len);

    always_comb begin
        o_rep.valid     = active && ((match && wrap) || (!match && (r_cur != '0)));
        o_rep.key       = r_key;
        o_rep.violation = !match;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_cur <= '0;
            r_len <= '0;
        end else begin
            if (i_adv) begin
                r_tok <= i_tok;
            end
            if (i_load.hdr_we && hit) begin
                r_len <= len_sat;
                r_cur <= '0;
            end else if (i_adv && active && match) begin
                r_cur <= wrap ? '0 : AW'(nxt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_id <= i_id;
        end
        if (i_load.hdr_we && hit) begin
            r_key <= i_load.key;
        end
    end

    assign o_tok = r_tok;
    assign o_id  = r_id;

endmodule

// File: rtl/css_chk.sv
// Port-level assertion checker for the checkpoint sequence supervisor, with bind
`timescale 1ns / 1ps
`include "checkpoint_sequence_supervisor_defines.svh"
module css_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic [css_pkg::CMD_W-1:0] i_in_cmd,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [css_pkg::KEY_W-1:0] i_out_key,
    input logic                      i_out_viol,
    input logic                      i_out_last
);

    logic load_xfer;
    logic out_stall;

    assign load_xfer = i_in_valid && i_in_ready && (i_in_cmd != css_pkg::CMD_CHECKPOINT);
    assign out_stall = i_out_valid && !i_out_ready;

    `CSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_out_key) && $stable(i_out_viol) && $stable(i_out_last), "report changed while stalled")
    `CSS_ASSERT_RESET(a_rst_no_report, i_clk, i_rst_n, !i_out_valid, "report valid after reset")
    `CSS_ASSERT_NEXT(a_load_ready, i_clk, i_rst_n, load_xfer, i_in_ready, "not ready after load transfer")
    `CSS_ASSERT_NEXT(a_load_no_report, i_clk, i_rst_n, load_xfer && !out_stall, !i_out_valid, "report after load transfer")

endmodule

bind checkpoint_sequence_supervisor css_chk u_css_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cp.valid),
    .i_in_ready  (i_cp.ready),
    .i_in_cmd    (i_cp.cmd),
    .i_out_valid (o_rep.valid),
    .i_out_ready (o_rep.ready),
    .i_out_key   (o_rep.report_key),
    .i_out_viol  (o_rep.violation),
    .i_out_last  (o_rep.last)
);
